// ===== hw/rtl/table_weighted_symbol_substitution_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the table-weighted symbol substitution unit.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TABLE_WEIGHTED_SYMBOL_SUBSTITUTION_UNIT_DEFINES_SVH
`define TABLE_WEIGHTED_SYMBOL_SUBSTITUTION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tws checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tws checker: next-cycle property failed");

`endif

// ===== hw/rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and codes of the table-weighted symbol substitution unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

	// Command codes of a request.
	localparam logic [1:0] CMD_LOAD_LABEL  = 2'd0;
	localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
	localparam logic [1:0] CMD_SUBSTITUTE  = 2'd2;

	// Status codes of a response.
	localparam logic [1:0] ST_SUBSTITUTED = 2'd0;
	localparam logic [1:0] ST_NO_COLUMN   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN     = 2'd2;
	localparam logic [1:0] ST_LOAD_DONE   = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  row_index;
		logic [4:0]  col_index;
		logic [15:0] weight_value;
		logic [7:0]  symbol_code;
		logic [15:0] random_fraction;
	} tws_req_t;

	typedef struct packed {
		logic [7:0] result_symbol;
		logic [1:0] status;
	} tws_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SEARCH,
		S_SUM,
		S_WALK,
		S_FINISH
	} tws_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic load;
		logic search;
		logic sum;
		logic walk;
		logic publish;
	} tws_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_subst;
		logic hit;
		logic miss;
		logic sum_done;
		logic walk_done;
		logic out_free;
	} tws_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tws_req_if.sv =====
// ----------------------------------------------------------------------------
// tws_req_if
// Request channel: valid, ready and one request item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tws_req_if;
	import tws_pkg::*;

	logic     valid;
	logic     ready;
	tws_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tws_rsp_if
// Response channel: valid, ready and one result item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tws_rsp_if;
	import tws_pkg::*;

	logic     valid;
	logic     ready;
	tws_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tws_ctrl.sv =====
// ----------------------------------------------------------------------------
// tws_ctrl
// Sequencer that steps one request through load, or through search, sum and walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tws_pkg::tws_stat_t stat,
	output tws_pkg::tws_cmd_t  cmd
);
	import tws_pkg::*;

	tws_state_t state_q;
	tws_state_t state_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = stat.in_subst ? S_SEARCH : S_LOAD;
				end
			end
			S_LOAD: begin
				state_d = S_FINISH;
			end
			S_SEARCH: begin
				if (stat.hit) begin
					state_d = S_SUM;
				end else if (stat.miss) begin
					state_d = S_FINISH;
				end
			end
			S_SUM: begin
				if (stat.sum_done) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.walk_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
			end
			S_FINISH: begin
				cmd.publish = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tws_datapath.sv =====
// ----------------------------------------------------------------------------
// tws_datapath
// Label and weight memories, index counter, accumulators and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tws_datapath #(
	parameter int NUM_SYMBOLS = 20,
	parameter int WEIGHT_BITS = 16,
	parameter int RAND_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tws_pkg::tws_req_t  in_data,
	input  logic               out_ready,
	input  tws_pkg::tws_cmd_t  cmd,
	output tws_pkg::tws_stat_t stat,
	output logic               out_valid,
	output tws_pkg::tws_rsp_t  out_data
);
	import tws_pkg::*;

	localparam int IDX_W   = $clog2(NUM_SYMBOLS);
	localparam int CNT_W   = $clog2(NUM_SYMBOLS + 1);
	localparam int WADDR_W = $clog2(NUM_SYMBOLS * NUM_SYMBOLS);
	localparam int SUM_W   = WEIGHT_BITS + $clog2(NUM_SYMBOLS);
	localparam int PROD_W  = RAND_BITS + WEIGHT_BITS;
	localparam int PACC_W  = RAND_BITS + SUM_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SYMBOLS - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_SYMBOLS);

	logic [7:0]             label_mem [NUM_SYMBOLS];
	logic [WEIGHT_BITS-1:0] weight_mem [NUM_SYMBOLS * NUM_SYMBOLS];

	tws_req_t               req_q;
	tws_rsp_t               res_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [7:0]             label_rd_s1;
	logic [WEIGHT_BITS-1:0] weight_rd_s1;
	logic                   pvld_s2;
	logic                   plast_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [PACC_W-1:0]      pacc_q;
	logic [SUM_W-1:0]       run_q;
	logic [WADDR_W-1:0]     row_base_q;
	logic                   out_valid_q;
	tws_rsp_t               out_data_q;

	logic                   issue;
	logic                   label_rd_en;
	logic                   weight_rd_en;
	logic [IDX_W-1:0]       cnt_idx;
	logic [WADDR_W-1:0]     weight_rd_addr;
	logic                   label_we;
	logic                   weight_we;
	logic [IDX_W-1:0]       wr_row;
	logic [IDX_W-1:0]       wr_col;
	logic [WADDR_W-1:0]     weight_wr_addr;
	logic                   match;
	logic                   last_s1;
	logic [SUM_W-1:0]       run_next;
	logic                   walk_hit;
	logic                   walk_end;
	logic [RAND_BITS-1:0]   frac;

	assign issue          = cnt_q < CNT_END;
	assign cnt_idx        = cnt_q[IDX_W-1:0];
	assign label_rd_en    = (cmd.search || cmd.walk) && issue;
	assign weight_rd_en   = (cmd.sum || cmd.walk) && issue;
	assign weight_rd_addr = row_base_q + WADDR_W'(cnt_idx);

	assign wr_row         = IDX_W'(req_q.row_index);
	assign wr_col         = IDX_W'(req_q.col_index);
	assign weight_wr_addr = WADDR_W'(wr_row) * WADDR_W'(NUM_SYMBOLS) + WADDR_W'(wr_col);
	assign label_we       = cmd.load && (req_q.command == CMD_LOAD_LABEL)
		&& (32'(req_q.col_index) < NUM_SYMBOLS);
	assign weight_we      = cmd.load && (req_q.command == CMD_LOAD_WEIGHT)
		&& (32'(req_q.row_index) < NUM_SYMBOLS) && (32'(req_q.col_index) < NUM_SYMBOLS);

	assign frac     = RAND_BITS'(req_q.random_fraction);
	assign match    = label_rd_s1 == req_q.symbol_code;
	assign last_s1  = idx_s1 == LAST_IDX;
	assign run_next = run_q + SUM_W'(weight_rd_s1);
	assign walk_hit = cmd.walk && vld_s1 && (pacc_q < {run_next, {RAND_BITS{1'b0}}});
	assign walk_end = cmd.walk && vld_s1 && last_s1 && !walk_hit;

	assign stat.in_subst  = in_data.command == CMD_SUBSTITUTE;
	assign stat.hit       = cmd.search && vld_s1 && match;
	assign stat.miss      = cmd.search && vld_s1 && !match && last_s1;
	assign stat.sum_done  = cmd.sum && pvld_s2 && plast_s2;
	assign stat.walk_done = walk_hit || walk_end;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Memories: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (label_we) begin
			label_mem[wr_col] <= req_q.symbol_code;
		end
		if (label_rd_en) begin
			label_rd_s1 <= label_mem[cnt_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[weight_wr_addr] <= WEIGHT_BITS'(req_q.weight_value);
		end
		if (weight_rd_en) begin
			weight_rd_s1 <= weight_mem[weight_rd_addr];
		end
	end

	// Index counter and read-valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			pvld_s2  <= 1'b0;
		end else begin
			pvld_s2 <= cmd.sum && vld_s1;
			if (cmd.start || stat.hit || stat.sum_done) begin
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
			end else if ((cmd.search || cmd.sum || cmd.walk) && issue) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				vld_s1 <= 1'b1;
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1   <= cnt_idx;
		plast_s2 <= last_s1;
		prod_s2  <= PROD_W'(frac) * PROD_W'(weight_rd_s1);
		if (cmd.start) begin
			req_q  <= in_data;
			pacc_q <= '0;
			run_q  <= '0;
		end
		if (stat.hit) begin
			row_base_q <= WADDR_W'(idx_s1) * WADDR_W'(NUM_SYMBOLS);
		end
		if (cmd.sum && pvld_s2) begin
			pacc_q <= pacc_q + PACC_W'(prod_s2);
		end
		if (cmd.walk && vld_s1) begin
			run_q <= run_next;
		end
		if (cmd.load) begin
			res_q.result_symbol <= 8'd0;
			res_q.status        <= ST_LOAD_DONE;
		end else if (stat.miss) begin
			res_q.result_symbol <= req_q.symbol_code;
			res_q.status        <= ST_UNKNOWN;
		end else if (walk_hit) begin
			res_q.result_symbol <= label_rd_s1;
			res_q.status        <= ST_SUBSTITUTED;
		end else if (walk_end) begin
			res_q.result_symbol <= req_q.symbol_code;
			res_q.status        <= ST_NO_COLUMN;
		end
		if (cmd.publish) begin
			out_data_q <= res_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/table_weighted_symbol_substitution_unit.sv =====
// ----------------------------------------------------------------------------
// table_weighted_symbol_substitution_unit: label/weight table sampler.
// A load runs the load and finish states; a substitute runs search, sum,
// walk and finish, or search and finish on a miss. The next transfer is
// taken back in idle. Reset clears control; tables undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// A substitute request runs three passes, each reading one slot per cycle:
//   search - the label memory is read slot by slot until the symbol matches
//            (lowest slot wins); no match gives status unknown symbol.
//   sum    - the matched row of the weight memory is read and fraction*weight
//            is accumulated, which equals fraction times the row sum.
//   walk   - the row is read again with a running sum; the first column whose
//            running sum shifted by RAND_BITS exceeds the accumulated product
//            supplies its label, read in the same cycle from the label memory.
// The comparison is exact integer arithmetic, so no division is needed.
// The result sits in an output register, so the next request is taken as
// soon as the sequencer is back in idle even if the response is still held.

module table_weighted_symbol_substitution_unit #(
	parameter int NUM_SYMBOLS = 20,
	parameter int WEIGHT_BITS = 16,
	parameter int RAND_BITS   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	tws_req_if.sink   request,
	tws_rsp_if.source response
);
	import tws_pkg::*;

	tws_cmd_t  cmd;
	tws_stat_t stat;

	// The controller sequences the passes; it sees the datapath only
	// through the command and status structs.
	tws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds both memories, the index counter, the product
	// accumulator, the running sum and the output register.
	tws_datapath #(
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RAND_BITS   (RAND_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (request.data),
		.out_ready (response.ready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (response.valid),
		.out_data  (response.data)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tws_checker.sv =====
// ----------------------------------------------------------------------------
// tws_checker
// Port-level properties of the substitution unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "table_weighted_symbol_substitution_unit_defines.svh"

module tws_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tws_pkg::tws_rsp_t rsp_data
);
	import tws_pkg::*;

	// A held response keeps its valid and its payload.
	`TWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`TWS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))

	// Every accepted request leaves the unit busy in the cycle after it.
	`TWS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

	// A new response is only published out of a busy cycle.
	`TWS_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(!req_ready))

	// Load responses carry a zero symbol.
	`TWS_ASSERT_SAME(a_load_zero, rsp_valid && (rsp_data.status == ST_LOAD_DONE),
		rsp_data.result_symbol == 8'd0)

endmodule

bind table_weighted_symbol_substitution_unit tws_checker u_tws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.rsp_valid (response.valid),
	.rsp_ready (response.ready),
	.rsp_data  (response.data)
);

`default_nettype wire
